>>> rtl/core/lcs_pkg.sv
`default_nettype none

package lcs_pkg;

    localparam int unsigned CAPACITY = 16;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned CFG_W    = 5;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(16);

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } t_rec;

    typedef struct packed {
        logic shift;
        logic evict;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/core/lcs_cell.sv
`default_nettype none

// One position of the recency chain. Position 0 is the most recent record.
module lcs_cell (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  lcs_pkg::t_cell_ctl               i_ctl,
    input  lcs_pkg::t_rec                    i_prev,
    input  wire [lcs_pkg::KEY_W-1:0]         i_search_key,
    output lcs_pkg::t_rec                    o_rec,
    output logic                             o_match
);

    logic                       r_valid;
    logic [lcs_pkg::KEY_W-1:0]  r_key;
    logic [lcs_pkg::SIZE_W-1:0] r_size;
    logic                       n_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_valid = i_prev.valid;
        end
        // Eviction wins over a shift: the record falling past the limit is dropped.
        if (i_ctl.evict) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key  <= i_prev.key;
            r_size <= i_prev.size;
        end
    end

    assign o_rec.valid = r_valid;
    assign o_rec.key   = r_key;
    assign o_rec.size  = r_size;
    assign o_match     = r_valid && (r_key == i_search_key);

endmodule

`default_nettype wire

>>> rtl/core/lru_content_store.sv
// Fully associative content store with least recently used replacement.
// Request channel (i_in_valid / o_in_ready) carries a command, a 64-bit key
// and a content size. A lookup returns one response on the output channel
// (o_out_valid / i_out_ready) with hit and stored size; an add returns none.
// Records sit in a chain of cells ordered by recency. Every request is
// compared against all cells at once and the chain shifts in the same cycle,
// so one request is taken per clock and a lookup response appears in the cycle
// after acceptance. The output register is the only stage: while a response
// waits, a new request is still taken if the receiver takes the response in
// the same cycle; a stalled receiver holds off further requests.
// i_cfg_we writes max_entries (0 acts as 1, values above the capacity act as
// the capacity). Lowering it evicts nothing until the next add, which trims
// the store to at most that many records.
// Synchronous reset empties the store, drops any pending response and sets
// max_entries to 16. There is no clearing pass; requests are taken at once.
`default_nettype none

module lru_content_store #(
    parameter int unsigned CAPACITY = lcs_pkg::CAPACITY
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [lcs_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_command,
    input  wire [lcs_pkg::KEY_W-1:0]     i_key,
    input  wire [lcs_pkg::SIZE_W-1:0]    i_content_size,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_hit,
    output logic [lcs_pkg::SIZE_W-1:0]   o_stored_size
);

    logic [lcs_pkg::CFG_W-1:0]  r_max_entries;
    logic [lcs_pkg::CFG_W-1:0]  lim;
    logic                       r_out_valid;
    logic                       r_hit;
    logic [lcs_pkg::SIZE_W-1:0] r_size;

    logic                       acc;
    logic                       acc_add;
    logic                       acc_lookup;
    logic                       any_hit;
    logic [lcs_pkg::SIZE_W-1:0] hit_size;
    logic [CAPACITY-1:0]        match;

    lcs_pkg::t_rec      rec  [CAPACITY];
    lcs_pkg::t_rec      head;
    lcs_pkg::t_cell_ctl ctl  [CAPACITY];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign acc        = i_in_valid && o_in_ready;
    assign acc_add    = acc && (i_command == lcs_pkg::CMD_ADD);
    assign acc_lookup = acc && (i_command == lcs_pkg::CMD_LOOKUP);
    assign lim        = (r_max_entries == '0) ? lcs_pkg::CFG_W'(1) : r_max_entries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= lcs_pkg::MAX_ENTRIES_RST;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_wdata;
        end
    end

    // Keys are unique among valid cells, so at most one match drives the OR.
    always_comb begin
        hit_size = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            if (match[j]) begin
                hit_size = hit_size | rec[j].size;
            end
        end
    end
    assign any_hit = |match;

    // The record entering at the head: the new one on add, the hit one on lookup.
    always_comb begin
        head.valid = 1'b1;
        head.key   = i_key;
        head.size  = (i_command == lcs_pkg::CMD_ADD) ? i_content_size : hit_size;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam int unsigned CellIdx = i;
        logic at_or_after;

        // Cells up to and including the matching one move back by one place; an add that misses moves every cell.
        assign at_or_after = |match[CAPACITY-1:i];
        assign ctl[i].shift = (acc_lookup && at_or_after)
                           || (acc_add && (at_or_after || !any_hit));
        assign ctl[i].evict = acc_add && (CellIdx >= 32'(lim));

        lcs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl[i]),
            .i_prev       ((i == 0) ? head : rec[(i == 0) ? 0 : i-1]),
            .i_search_key (i_key),
            .o_rec        (rec[i]),
            .o_match      (match[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc_lookup) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_lookup) begin
            r_hit  <= any_hit;
            r_size <= any_hit ? hit_size : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_stored_size = r_size;

endmodule

`default_nettype wire

>>> rtl/core/lcs_checker.sv
`default_nettype none

module lcs_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          o_in_ready,
    input  wire                          i_command,
    input  wire [lcs_pkg::KEY_W-1:0]     i_key,
    input  wire [lcs_pkg::SIZE_W-1:0]    i_content_size,
    input  wire                          o_out_valid,
    input  wire                          i_out_ready,
    input  wire                          o_hit,
    input  wire [lcs_pkg::SIZE_W-1:0]    o_stored_size
);

    logic acc;
    assign acc = i_in_valid && o_in_ready;

    // A lookup request always yields a response in the next cycle.
    a_lookup_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_command == lcs_pkg::CMD_LOOKUP) |=> o_out_valid)
        else $error("lookup request produced no response");

    // A miss reports a size of zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_stored_size == '0)
        else $error("miss response carries a nonzero size");

    // A record just added is the most recent and must be found right away.
    a_add_then_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_command == lcs_pkg::CMD_ADD))
        ##1 (acc && (i_command == lcs_pkg::CMD_LOOKUP) && (i_key == $past(i_key)))
        |=> o_hit && (o_stored_size == $past(i_content_size, 2)))
        else $error("freshly added record not found");

    // A stalled response holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit)
        && $stable(o_stored_size))
        else $error("stalled response changed");

endmodule

bind lru_content_store lcs_checker u_lcs_checker (.*);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic                      cmd;
        logic [lcs_pkg::KEY_W-1:0]  key;
        logic [lcs_pkg::SIZE_W-1:0] size;
    } t_cs_request;

    typedef struct packed {
        logic                      hit;
        logic [lcs_pkg::SIZE_W-1:0] size;
    } t_lookup_reply;

    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS   = 160;
    localparam int unsigned MAX_POOL      = 32;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [lcs_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_cs_request cur_req = '0;

    logic o_in_ready;
    logic o_out_valid;
    logic o_hit;
    logic [lcs_pkg::SIZE_W-1:0] o_stored_size;

    // Shadow copy of the store contents and its limit register.
    logic [lcs_pkg::KEY_W-1:0]  rec_key [lcs_pkg::CAPACITY];
    logic [lcs_pkg::SIZE_W-1:0] rec_size [lcs_pkg::CAPACITY];
    bit                         rec_valid [lcs_pkg::CAPACITY];
    int unsigned                rec_rank [lcs_pkg::CAPACITY];
    logic [lcs_pkg::CFG_W-1:0]  limit_reg = lcs_pkg::MAX_ENTRIES_RST;

    t_cs_request   requests_to_send[$];
    t_lookup_reply lookup_replies_due[$];

    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;
    int errors = 0;

    lru_content_store dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (cur_req.cmd),
        .i_key          (cur_req.key),
        .i_content_size (cur_req.size),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_hit          (o_hit),
        .o_stored_size  (o_stored_size)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("lru_content_store: mismatch");
        $finish;
    end

    function automatic int unsigned idle_draw(bit burst);
        return burst ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic int unsigned effective_limit();
        if (limit_reg == 0) return 1;
        if (limit_reg > lcs_pkg::CAPACITY) return lcs_pkg::CAPACITY;
        return 32'(limit_reg);
    endfunction

    // Applies one request to the shadow store; a lookup yields a reply.
    function automatic void cache_access(input t_cs_request rq, output bit replies,
                                         output t_lookup_reply rep);
        int slot;
        int i;
        int unsigned old_rank;
        int unsigned keep;
        slot = -1;
        rep = '0;
        for (i = 0; i < lcs_pkg::CAPACITY; i++)
            if (slot < 0 && rec_valid[i] && rec_key[i] == rq.key) slot = i;

        if (rq.cmd == lcs_pkg::CMD_LOOKUP) begin
            replies = 1'b1;
            if (slot >= 0) begin
                for (i = 0; i < lcs_pkg::CAPACITY; i++)
                    if (rec_valid[i] && rec_rank[i] < rec_rank[slot]) rec_rank[i]++;
                rec_rank[slot] = 0;
                rep.hit = 1'b1;
                rep.size = rec_size[slot];
            end
            return;
        end

        replies = 1'b0;
        if (slot >= 0) begin
            old_rank = rec_rank[slot];
            rec_valid[slot] = 1'b0;
            rec_rank[slot] = 0;
            for (i = 0; i < lcs_pkg::CAPACITY; i++)
                if (rec_valid[i] && rec_rank[i] > old_rank) rec_rank[i]--;
        end

        // Trim to one below the limit, which also handles a lowered limit.
        keep = effective_limit() - 1;
        for (i = 0; i < lcs_pkg::CAPACITY; i++)
            if (rec_valid[i] && rec_rank[i] >= keep) begin
                rec_valid[i] = 1'b0;
                rec_rank[i] = 0;
            end

        slot = -1;
        for (i = 0; i < lcs_pkg::CAPACITY; i++)
            if (slot < 0 && !rec_valid[i]) slot = i;
        for (i = 0; i < lcs_pkg::CAPACITY; i++)
            if (rec_valid[i]) rec_rank[i]++;
        rec_key[slot] = rq.key;
        rec_size[slot] = rq.size;
        rec_valid[slot] = 1'b1;
        rec_rank[slot] = 0;
    endfunction

    // Request side.
    always @(posedge i_clk) begin : send_side
        bit pred_out;
        t_lookup_reply pred;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                cache_access(cur_req, pred_out, pred);
                if (pred_out) lookup_replies_due.push_back(pred);
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (requests_to_send.size() != 0) begin
                    cur_req <= requests_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= idle_draw(send_burst);
                    if ($urandom_range(0, 47) == 0) send_burst <= !send_burst;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Response side.
    always @(posedge i_clk) begin : recv_side
        t_lookup_reply want;
        int unsigned stall_now;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_stall <= 0;
        end else if (o_out_valid && out_ready) begin
            if (lookup_replies_due.size() == 0) begin
                errors++;
                $display("%0t: response with none pending: hit %0b size %h",
                         $time, o_hit, o_stored_size);
            end else begin
                want = lookup_replies_due.pop_front();
                if (o_hit !== want.hit) begin
                    errors++;
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_hit);
                end
                if (o_stored_size !== want.size) begin
                    errors++;
                    $display("%0t: stored_size expected %h actual %h",
                             $time, want.size, o_stored_size);
                end
            end
            stall_now = idle_draw(recv_burst);
            recv_stall <= stall_now;
            out_ready <= (stall_now == 0);
            if ($urandom_range(0, 47) == 0) recv_burst <= !recv_burst;
        end else if (recv_stall != 0) begin
            recv_stall <= recv_stall - 1;
            out_ready <= (recv_stall == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic queue_request(logic cmd, logic [lcs_pkg::KEY_W-1:0] key,
                                 logic [lcs_pkg::SIZE_W-1:0] size);
        t_cs_request rq;
        rq.cmd = cmd;
        rq.key = key;
        rq.size = size;
        requests_to_send.push_back(rq);
    endtask

    // Sampled at the falling edge so that every update of the rising edge has settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (requests_to_send.size() != 0 || in_valid || lookup_replies_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [lcs_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        limit_reg = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [lcs_pkg::KEY_W-1:0] key_pool [MAX_POOL];
        logic [lcs_pkg::CFG_W-1:0] limit_plan [RANDOM_PHASES];
        int unsigned pool_n;
        int unsigned ph;
        int unsigned n;
        logic [lcs_pkg::KEY_W-1:0] k;
        logic [lcs_pkg::SIZE_W-1:0] sz;

        for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
            rec_valid[i] = 1'b0;
            rec_rank[i] = 0;
        end
        limit_plan = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd2, 5'd5, 5'd8, 5'd3, 5'd12,
                       5'd16, 5'd31};
        limit_plan[9] = lcs_pkg::CFG_W'($urandom_range(0, 31));
        limit_plan[10] = lcs_pkg::CFG_W'($urandom_range(0, 31));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty store, both key extremes, size extremes, replace and reordering.
        queue_request(lcs_pkg::CMD_LOOKUP, '0, 16'h1234);
        queue_request(lcs_pkg::CMD_ADD, '0, 16'h0000);
        queue_request(lcs_pkg::CMD_ADD, '1, 16'hFFFF);
        queue_request(lcs_pkg::CMD_LOOKUP, '0, '1);
        queue_request(lcs_pkg::CMD_LOOKUP, '1, '0);
        queue_request(lcs_pkg::CMD_ADD, '1, 16'h5A5A);
        queue_request(lcs_pkg::CMD_LOOKUP, '1, '0);
        queue_request(lcs_pkg::CMD_ADD, 64'd1, 16'd1);
        queue_request(lcs_pkg::CMD_ADD, 64'd2, 16'd2);
        queue_request(lcs_pkg::CMD_ADD, 64'd3, 16'd3);
        queue_request(lcs_pkg::CMD_ADD, 64'd4, 16'd4);
        queue_request(lcs_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0000, '0);
        queue_request(lcs_pkg::CMD_LOOKUP, '0, '0);
        wait_idle();

        // A lowered limit keeps the surplus visible until the next add trims it.
        write_limit(5'd2);
        queue_request(lcs_pkg::CMD_LOOKUP, 64'd2, '0);
        queue_request(lcs_pkg::CMD_LOOKUP, 64'd3, '0);
        queue_request(lcs_pkg::CMD_LOOKUP, '0, '0);
        queue_request(lcs_pkg::CMD_ADD, 64'd5, 16'h0505);
        queue_request(lcs_pkg::CMD_LOOKUP, 64'd5, '0);
        queue_request(lcs_pkg::CMD_LOOKUP, '0, '0);
        queue_request(lcs_pkg::CMD_LOOKUP, 64'd3, '0);
        queue_request(lcs_pkg::CMD_LOOKUP, '1, '0);
        wait_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_limit(limit_plan[ph]);
            // A pool of 2 to limit+8 keys gives a mix of hits and evictions.
            pool_n = $urandom_range(2, effective_limit() + 8);
            if (pool_n > MAX_POOL) pool_n = MAX_POOL;
            for (int i = 0; i < MAX_POOL; i++) key_pool[i] = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) key_pool[0] = '0;
            if ($urandom_range(0, 3) == 0) key_pool[1] = '1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, pool_n - 1)];
                else
                    k = {$urandom, $urandom};
                case ($urandom_range(0, 15))
                    0: sz = '0;
                    1: sz = '1;
                    default: sz = lcs_pkg::SIZE_W'($urandom);
                endcase
                queue_request($urandom_range(0, 1) ? lcs_pkg::CMD_ADD : lcs_pkg::CMD_LOOKUP,
                              k, sz);
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0 && lookup_replies_due.size() == 0)
            $display("lru_content_store: match");
        else
            $display("lru_content_store: mismatch");
        $finish;
    end

endmodule

>>> lru_content_store.f
rtl/core/lcs_pkg.sv
rtl/core/lcs_cell.sv
rtl/core/lru_content_store.sv
rtl/core/lcs_checker.sv
verif/tb.sv
